### src/card_number_luhn_classifier_assert.svh
// ---------------------------------------------------------------------------
// Card number Luhn classifier: assertion macros
// Shared helpers for concurrent checks, clocked on clk and cut off in reset.
// ---------------------------------------------------------------------------
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define CNLC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CNLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cnlc_pkg.sv
// ---------------------------------------------------------------------------
// Card number Luhn classifier package
// Widths, length limits, class codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

	localparam int CARD_W        = 63;
	localparam int CLASS_W       = 2;
	localparam int COUNT_W       = 5;
	localparam int DIGIT_W       = 4;
	localparam int NUM_DIGITS    = 19;
	localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
	localparam int BIN_W         = 64;
	localparam int BITS_PER_STEP = 8;
	localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

	localparam logic [COUNT_W-1:0] MIN_DIGITS = 5'd13;
	localparam logic [COUNT_W-1:0] MAX_DIGITS = 5'd16;
	localparam logic [COUNT_W-1:0] LEN_SHORT  = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_MID    = 5'd15;
	localparam logic [COUNT_W-1:0] LEN_LONG   = 5'd16;

	localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_LEAD4 = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_LEAD3 = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_LEAD5 = 2'd3;

	typedef struct packed {
		logic load;
		logic convert;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic digits_left;
	} status_t;

endpackage

`default_nettype wire

### src/cnlc_dp.sv
// ---------------------------------------------------------------------------
// Card number Luhn classifier datapath
// Binary-to-BCD conversion, digit scan with running Luhn sum, and the
// registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module cnlc_dp #(
	parameter logic [cnlc_pkg::COUNT_W-1:0] MAX_DIGITS = cnlc_pkg::MAX_DIGITS
) (
	input  wire                                 clk,
	input  cnlc_pkg::cmd_t                      cmd,
	output cnlc_pkg::status_t                   status,
	input  wire  [cnlc_pkg::CARD_W-1:0]         pan,
	output logic [cnlc_pkg::CLASS_W-1:0]        card_class,
	output logic                                luhn_valid,
	output logic [cnlc_pkg::COUNT_W-1:0]        digit_count
);

	localparam int DW  = cnlc_pkg::DIGIT_W;
	localparam int BPS = cnlc_pkg::BITS_PER_STEP;

	// Several shift-and-add-3 steps of the double-dabble conversion.
	function automatic logic [cnlc_pkg::BCD_W-1:0] dabble(
		input logic [cnlc_pkg::BCD_W-1:0] bcd_in,
		input logic [BPS-1:0]             bits
	);
		logic [cnlc_pkg::BCD_W-1:0] b;
		b = bcd_in;
		for (int i = 0; i < BPS; i++) begin
			for (int k = 0; k < cnlc_pkg::NUM_DIGITS; k++) begin
				if (b[k*DW +: DW] >= 4'd5) begin
					b[k*DW +: DW] = b[k*DW +: DW] + 4'd3;
				end
			end
			b = {b[cnlc_pkg::BCD_W-2:0], bits[BPS-1-i]};
		end
		return b;
	endfunction

	logic [cnlc_pkg::BCD_W-1:0]   bcd_q;
	logic [cnlc_pkg::BIN_W-1:0]   bin_q;
	logic [cnlc_pkg::COUNT_W-1:0] count_q;
	logic [DW-1:0]                sum_q;
	logic [DW-1:0]                lead_q;
	logic [DW-1:0]                second_q;
	logic [cnlc_pkg::CLASS_W-1:0] card_class_q;
	logic                         luhn_valid_q;
	logic [cnlc_pkg::COUNT_W-1:0] digit_count_q;

	logic [DW-1:0] digit;
	logic [4:0]    doubled;
	logic [4:0]    addend;
	logic [4:0]    sum_raw;
	logic [DW-1:0] sum_next;
	logic          len_ok;
	logic          pass;
	logic          lead4;
	logic          lead34_37;
	logic          lead51_55;
	logic [cnlc_pkg::CLASS_W-1:0] class_next;

	assign digit   = bcd_q[DW-1:0];
	assign doubled = {digit, 1'b0};
	// Even positions (odd count so far) are doubled, with the product's digits summed.
	assign addend  = count_q[0] ? ((doubled >= 5'd10) ? doubled - 5'd9 : doubled)
	                            : {1'b0, digit};
	assign sum_raw  = {1'b0, sum_q} + addend;
	assign sum_next = (sum_raw >= 5'd10) ? DW'(sum_raw - 5'd10) : DW'(sum_raw);

	assign status.digits_left = |bcd_q;

	assign len_ok    = (count_q >= cnlc_pkg::MIN_DIGITS) && (count_q <= MAX_DIGITS);
	assign pass      = len_ok && (sum_q == 4'd0);
	assign lead4     = (lead_q == 4'd4);
	assign lead34_37 = (lead_q == 4'd3) && ((second_q == 4'd4) || (second_q == 4'd7));
	assign lead51_55 = (lead_q == 4'd5) && (second_q >= 4'd1) && (second_q <= 4'd5);

	always_comb begin
		class_next = cnlc_pkg::CLASS_NONE;
		if (pass) begin
			if (count_q == cnlc_pkg::LEN_SHORT) begin
				if (lead4) class_next = cnlc_pkg::CLASS_LEAD4;
			end else if (count_q == cnlc_pkg::LEN_MID) begin
				if (lead34_37)  class_next = cnlc_pkg::CLASS_LEAD3;
				else if (lead4) class_next = cnlc_pkg::CLASS_LEAD4;
			end else if (count_q == cnlc_pkg::LEN_LONG) begin
				if (lead51_55)  class_next = cnlc_pkg::CLASS_LEAD5;
				else if (lead4) class_next = cnlc_pkg::CLASS_LEAD4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q    <= {1'b0, pan};
			bcd_q    <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			lead_q   <= '0;
			second_q <= '0;
		end else if (cmd.convert) begin
			bcd_q <= dabble(bcd_q, bin_q[cnlc_pkg::BIN_W-1 -: BPS]);
			bin_q <= {bin_q[cnlc_pkg::BIN_W-BPS-1:0], {BPS{1'b0}}};
		end else if (cmd.scan) begin
			// The last two digits shifted out are the leading two of the number.
			bcd_q    <= {{DW{1'b0}}, bcd_q[cnlc_pkg::BCD_W-1:DW]};
			count_q  <= count_q + 5'd1;
			sum_q    <= sum_next;
			second_q <= lead_q;
			lead_q   <= digit;
		end
		if (cmd.emit) begin
			card_class_q  <= class_next;
			luhn_valid_q  <= pass;
			digit_count_q <= count_q;
		end
	end

	assign card_class  = card_class_q;
	assign luhn_valid  = luhn_valid_q;
	assign digit_count = digit_count_q;

endmodule

`default_nettype wire

### src/cnlc_ctrl.sv
// ---------------------------------------------------------------------------
// Card number Luhn classifier controller
// Sequences load, conversion, digit scan and result hand-off; owns the
// handshake flags of both channels.
// ---------------------------------------------------------------------------
`default_nettype none

`include "card_number_luhn_classifier_assert.svh"

module cnlc_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                card_valid,
	output logic               card_stall,
	output logic               result_valid,
	input  wire                result_stall,
	output cnlc_pkg::cmd_t     cmd,
	input  cnlc_pkg::status_t  status
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CONV   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	localparam logic [cnlc_pkg::STEP_CNT_W-1:0] LAST_STEP =
		cnlc_pkg::STEP_CNT_W'(cnlc_pkg::CONV_STEPS - 1);

	logic [1:0]                        state_q;
	logic [1:0]                        state_next;
	logic [cnlc_pkg::STEP_CNT_W-1:0]   step_q;
	logic                              result_valid_q;
	logic                              card_take;
	logic                              out_free;

	assign card_stall = (state_q != ST_IDLE);
	assign card_take  = card_valid && !card_stall;
	assign out_free   = !result_valid_q || !result_stall;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (card_take) begin
					cmd.load   = 1'b1;
					state_next = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.convert = 1'b1;
				if (step_q == LAST_STEP) state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.digits_left) cmd.scan = 1'b1;
				else                    state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) begin
					cmd.emit   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CONV) step_q <= step_q + 1'b1;
			else                    step_q <= '0;
			if (cmd.emit)           result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	`CNLC_ASSERT_NEXT(a_take_starts_conv, card_take, state_q == ST_CONV, "accepted beat did not start conversion")
	`CNLC_ASSERT_NEXT(a_conv_ends_in_scan, (state_q == ST_CONV) && (step_q == LAST_STEP), state_q == ST_SCAN, "conversion overran")
	`CNLC_ASSERT_IMPL(a_emit_no_overwrite, cmd.emit, !result_valid_q || !result_stall, "held result overwritten")
	`CNLC_ASSERT_IMPL(a_result_from_emit, $rose(result_valid_q), $past(cmd.emit), "result beat without a decision")

endmodule

`default_nettype wire

### src/card_number_luhn_classifier.sv
// ---------------------------------------------------------------------------
// Card number Luhn classifier
// Counts the decimal digits of a binary card number, runs the mod-10 Luhn
// check and classifies the number by its length and leading digits.
//
//   channel  handshake                    payload
//   card     card_valid / card_stall      pan[62:0]
//   result   result_valid / result_stall  card_class[1:0], luhn_valid, digit_count[4:0]
//
// From acceptance to the next accept an item passes through the load, then
// binary-to-BCD conversion at eight bits a cycle, then the Luhn accumulator
// at one decimal digit a cycle, plus a scan step that finds no digit left,
// then the decision.
// The result sits in an output register, so a new card is taken while it waits.
// A stalled result holds the decision cycle until the output register frees.
// Reset clears the controller and the result valid flag only.
// ---------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier #(
	parameter logic [cnlc_pkg::COUNT_W-1:0] MAX_DIGITS = cnlc_pkg::MAX_DIGITS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  card_valid,
	output logic                                 card_stall,
	input  wire  [cnlc_pkg::CARD_W-1:0]          pan,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic [cnlc_pkg::CLASS_W-1:0]         card_class,
	output logic                                 luhn_valid,
	output logic [cnlc_pkg::COUNT_W-1:0]         digit_count
);

	cnlc_pkg::cmd_t    cmd;
	cnlc_pkg::status_t status;

	cnlc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.card_valid   (card_valid),
		.card_stall   (card_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	cnlc_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.pan         (pan),
		.card_class  (card_class),
		.luhn_valid  (luhn_valid),
		.digit_count (digit_count)
	);

endmodule

`default_nettype wire
